// ===== sv/qste_pkg.sv =====
// Shared types, constants and helpers for the quad step threshold estimator.
`timescale 1ns / 1ps

package qste_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned FoldW   = 10;
  localparam int unsigned NumSamp = 4;

  localparam logic [FoldW-1:0] FoldMax     = 10'd1023;
  localparam logic [FoldW-1:0] MinStep     = 10'd128;
  localparam logic [FoldW-1:0] Margin      = 10'd32;
  localparam logic [FoldW-1:0] FixedThresh = 10'd512;
  localparam logic [FoldW-1:0] MinReset    = 10'd1023;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [FoldW-1:0]   fold_t;

  // quad order: top-left, top-right, bottom-left, bottom-right
  typedef sample_t [NumSamp-1:0] quad_t;

  typedef struct packed {
    fold_t measure;    // largest pairwise difference of folded samples
    logic  high_step;  // bits 11:10 not equal across the quad
  } step_t;

  function automatic fold_t fold10(input sample_t s);
    fold_t low;
    low = s[FoldW-1:0];
    if (s[FoldW]) begin
      low = FoldMax - low;
    end
    return low;
  endfunction

  function automatic fold_t absdiff(input fold_t a, input fold_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic fold_t umax(input fold_t a, input fold_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== sv/qste_step.sv =====
// Per-quad step measure: fold, six pairwise differences, max tree, high-bit check.
`timescale 1ns / 1ps

module qste_step (
  input  qste_pkg::quad_t quad_i,
  output qste_pkg::step_t step_o
);

  qste_pkg::fold_t f0, f1, f2, f3;
  qste_pkg::fold_t d01, d02, d03, d12, d13, d23;
  qste_pkg::fold_t m_a, m_b, m_c;
  qste_pkg::fold_t measure;
  logic            high_step;

  assign f0 = qste_pkg::fold10(quad_i[0]);
  assign f1 = qste_pkg::fold10(quad_i[1]);
  assign f2 = qste_pkg::fold10(quad_i[2]);
  assign f3 = qste_pkg::fold10(quad_i[3]);

  assign d01 = qste_pkg::absdiff(f0, f1);
  assign d02 = qste_pkg::absdiff(f0, f2);
  assign d03 = qste_pkg::absdiff(f0, f3);
  assign d12 = qste_pkg::absdiff(f1, f2);
  assign d13 = qste_pkg::absdiff(f1, f3);
  assign d23 = qste_pkg::absdiff(f2, f3);

  // three-level max tree
  assign m_a = qste_pkg::umax(d01, d02);
  assign m_b = qste_pkg::umax(d03, d12);
  assign m_c = qste_pkg::umax(d13, d23);

  assign measure = qste_pkg::umax(qste_pkg::umax(m_a, m_b), m_c);

  assign high_step =
      !((quad_i[0][11:10] == quad_i[1][11:10]) &&
        (quad_i[1][11:10] == quad_i[2][11:10]) &&
        (quad_i[2][11:10] == quad_i[3][11:10]));

  assign step_o = '{measure: measure, high_step: high_step};

endmodule

// ===== sv/quad_step_threshold_estimator.sv =====
// Top level of the quad step threshold estimator: input register, step logic, result register.
`timescale 1ns / 1ps

// Takes one 2x2 quad of 12-bit depth samples per word on the slave stream,
// tlast marking the last quad of a threshold block, and emits one 10-bit
// threshold word per block on the master stream. Throughput is one quad per
// clock unless a block-last quad is held back; a quad goes through the input
// register, then the fold / difference / max / running-minimum logic
// feeding the result register. The input register keeps taking quads while
// a threshold waits to be read; only a block-last quad has to wait for the
// result register to free up. adapt_enable (cfg_wdata_i, reset 1) selects
// data-driven thresholds (running minimum of qualifying steps above 128,
// minus 32, clamped at 0) or a fixed 512; write it only while idle.
module quad_step_threshold_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // adapt_enable

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] sample_top_left, [23:12] sample_top_right,
  // [35:24] sample_bottom_left, [47:36] sample_bottom_right
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // block_last

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] threshold, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  // configuration
  logic adapt_q;

  // input register
  logic            in_vld_q, in_vld_d;
  qste_pkg::quad_t quad_q;
  logic            last_q;

  // running minimum and result register
  qste_pkg::fold_t min_q, min_d;
  logic            out_vld_q, out_vld_d;
  qste_pkg::fold_t thr_q, thr_d;

  qste_pkg::step_t step;
  qste_pkg::fold_t cand;
  logic            proc;
  logic            s_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adapt_q <= 1'b1;
    end else if (cfg_we_i) begin
      adapt_q <= cfg_wdata_i;
    end
  end

  // a quad leaves the input register unless it is block-last and the
  // result register is still occupied
  assign proc          = in_vld_q && (!last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      quad_q[0] <= s_axis_tdata[11:0];
      quad_q[1] <= s_axis_tdata[23:12];
      quad_q[2] <= s_axis_tdata[35:24];
      quad_q[3] <= s_axis_tdata[47:36];
      last_q    <= s_axis_tlast;
    end
  end

  qste_step u_step (
    .quad_i (quad_q),
    .step_o (step)
  );

  // minimum after this quad is folded in
  always_comb begin
    cand = min_q;
    if (step.high_step && (step.measure > qste_pkg::MinStep) && (step.measure < min_q)) begin
      cand = step.measure;
    end
  end

  always_comb begin
    min_d     = min_q;
    out_vld_d = out_vld_q;
    thr_d     = thr_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (proc) begin
      if (last_q) begin
        min_d     = qste_pkg::MinReset;
        out_vld_d = 1'b1;
        if (adapt_q) begin
          thr_d = (cand > qste_pkg::Margin) ? (cand - qste_pkg::Margin) : '0;
        end else begin
          thr_d = qste_pkg::FixedThresh;
        end
      end else begin
        min_d = cand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= qste_pkg::MinReset;
      out_vld_q <= 1'b0;
    end else begin
      min_q     <= min_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, thr_q};

`ifndef SYNTHESIS
  // minimum only ever takes steps above 128 or the reset value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q > qste_pkg::MinStep)
    else $error("running minimum at or below step floor");

  // block end returns the minimum to its reset value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |=> (min_q == qste_pkg::MinReset))
    else $error("running minimum not reset at block end");

  // a waiting threshold is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !(proc && last_q))
    else $error("threshold overwritten while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the quad step threshold estimator.
`timescale 1ns / 1ps

module tb;

  // Tracks the block state on the side of the bench and holds thresholds still owed.
  class threshold_scoreboard;
    bit              adapt_on;
    qste_pkg::fold_t block_min;
    qste_pkg::fold_t owed_q[$];
    int              errors;

    function new();
      adapt_on  = 1'b1;
      block_min = qste_pkg::MinReset;
      errors    = 0;
    endfunction

    function void set_adapt(bit v);
      adapt_on = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // low ten bits, mirrored when bit 10 is set
    function qste_pkg::fold_t fold_depth(qste_pkg::sample_t s);
      qste_pkg::fold_t v;
      v = s[qste_pkg::FoldW-1:0];
      return s[qste_pkg::FoldW] ? (qste_pkg::FoldMax - v) : v;
    endfunction

    // one accepted quad word
    function void note_quad(qste_pkg::quad_t q, bit last);
      qste_pkg::fold_t f[qste_pkg::NumSamp];
      qste_pkg::fold_t step;
      qste_pkg::fold_t d;
      bit              mixed;
      step  = '0;
      mixed = 1'b0;
      for (int i = 0; i < qste_pkg::NumSamp; i++) begin
        f[i] = fold_depth(q[i]);
        if (q[i][qste_pkg::SampleW-1:qste_pkg::FoldW] !=
            q[0][qste_pkg::SampleW-1:qste_pkg::FoldW]) begin
          mixed = 1'b1;
        end
      end
      for (int i = 0; i < qste_pkg::NumSamp; i++) begin
        for (int j = i + 1; j < qste_pkg::NumSamp; j++) begin
          d = (f[i] > f[j]) ? (f[i] - f[j]) : (f[j] - f[i]);
          if (d > step) begin
            step = d;
          end
        end
      end
      if (mixed && step > qste_pkg::MinStep && step < block_min) begin
        block_min = step;
      end
      if (last) begin
        if (!adapt_on) begin
          owed_q.push_back(qste_pkg::FixedThresh);
        end else if (block_min > qste_pkg::Margin) begin
          owed_q.push_back(block_min - qste_pkg::Margin);
        end else begin
          owed_q.push_back('0);
        end
        block_min = qste_pkg::MinReset;
      end
    endfunction

    // one accepted threshold word
    function void check_threshold(qste_pkg::fold_t got);
      qste_pkg::fold_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("threshold %0d arrived with none owed", got);
        end
      end else begin
        want = owed_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("threshold mismatch: expected %0d, got %0d", want, got);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [11:0] tl, [23:12] tr, [35:24] bl, [47:36] br
  logic        s_axis_tlast = 1'b0; // block_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [9:0] threshold, [15:10] zero

  threshold_scoreboard sb = new();

  bit src_idle;      // sender inserts random gaps
  bit sink_idle;     // receiver drops tready at random
  int hold_left;     // forced receiver hold-off, counted down at the falling edge
  int blk_left;      // quads left in the current random block

  quad_step_threshold_estimator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample both streams at the rising edge; result first so a same-edge quad
  // never lands ahead of an older threshold.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_threshold(m_axis_tdata[qste_pkg::FoldW-1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_quad(qste_pkg::quad_t'(s_axis_tdata), s_axis_tlast);
      end
    end
  end

  // Receiver: forced hold-off wins, otherwise random stalls when enabled.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= !(sink_idle && $urandom_range(99) < 23);
    end
  end

  function automatic qste_pkg::quad_t qd(qste_pkg::sample_t tl, qste_pkg::sample_t tr,
                                         qste_pkg::sample_t bl, qste_pkg::sample_t br);
    return {br, bl, tr, tl};
  endfunction

  // Random quad. Most are built from folded values in a narrow band so the step
  // lands near the 128 cutoff and the block minimum moves; the high bits are
  // random so some quads count and some do not.
  function automatic qste_pkg::quad_t make_quad();
    qste_pkg::quad_t q;
    int              pick;
    int              base;
    int              spread;
    int              f;
    bit [1:0]        hb;
    bit [1:0]        hb0;
    pick   = $urandom_range(99);
    base   = $urandom_range(0, 1023);
    spread = ($urandom_range(3) == 0) ? $urandom_range(0, 1023) : $urandom_range(100, 320);
    hb0    = 2'($urandom_range(0, 3));
    for (int i = 0; i < qste_pkg::NumSamp; i++) begin
      if (pick < 30) begin
        q[i] = 12'($urandom_range(0, 4095));
      end else begin
        f = base + $urandom_range(0, spread);
        if (f > 1023) begin
          f = 1023;
        end
        hb = (pick < 88) ? 2'($urandom_range(0, 3)) : hb0;   // else flat: never counts
        q[i] = {hb, hb[0] ? 10'(1023 - f) : 10'(f)};
      end
    end
    return q;
  endfunction

  // Offer one quad word at the falling edge and hold it until taken.
  task automatic send_quad(input qste_pkg::quad_t q, input bit last);
    while (src_idle && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every owed threshold, plus pipeline margin
  // for trailing non-last quads.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_adapt(input bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_adapt(v);
  endtask

  task automatic run_random(input int n);
    bit last;
    for (int i = 0; i < n; i++) begin
      if (blk_left == 0) begin
        blk_left = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      end
      blk_left--;
      last = (blk_left == 0);
      send_quad(make_quad(), last);
    end
  endtask

  initial begin
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_left = 0;
    blk_left  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_adapt(1'b1);

    // --- directed, adaptation on ---
    send_quad(qd(12'h000, 12'h000, 12'h000, 12'h000), 1'b1);  // nothing counts: 991
    send_quad(qd(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF), 1'b1);  // all ones, flat
    send_quad(qd(12'h000, 12'hFFF, 12'h400, 12'h3FF), 1'b1);  // step equals reset min
    send_quad(qd(12'h000, 12'd128, 12'h800, 12'h000), 1'b1);  // step at cutoff, ignored
    send_quad(qd(12'h000, 12'd129, 12'h800, 12'h000), 1'b1);  // just above cutoff
    send_quad(qd(12'h000, 12'd300, 12'h800, 12'h000), 1'b0);  // multi-quad block
    send_quad(qd(12'h800, 12'd200, 12'h000, 12'h000), 1'b0);
    send_quad(qd(12'h000, 12'd150, 12'h000, 12'h000), 1'b0);  // flat high bits, no count
    send_quad(qd(12'h800, 12'h800, 12'h000, 12'd250), 1'b1);
    send_quad(qd(12'h4FF, 12'h300, 12'hA58, 12'h300), 1'b1);  // mirrored fold
    send_quad(qd(12'hAAA, 12'h555, 12'hFFF, 12'h000), 1'b1);
    send_quad(qd(12'h000, 12'd140, 12'h800, 12'h000), 1'b0);  // block straddles a write
    settle();
    write_adapt(1'b0);
    send_quad(qd(12'h000, 12'h000, 12'h000, 12'h000), 1'b1);  // fixed 512, min resets
    send_quad(qd(12'h000, 12'd129, 12'h800, 12'h000), 1'b0);
    send_quad(qd(12'h000, 12'd500, 12'h800, 12'h000), 1'b1);
    send_quad(qd(12'h000, 12'd300, 12'h800, 12'h000), 1'b0);  // min kept while off
    settle();
    write_adapt(1'b1);
    send_quad(qd(12'h000, 12'h000, 12'h000, 12'h000), 1'b1);  // 268 from the held min
    send_quad(qd(12'h000, 12'h000, 12'h000, 12'h000), 1'b1);  // back to 991
    settle();

    // --- random, no idling anywhere ---
    run_random(400);
    settle();
    write_adapt(1'b0);

    // --- random with idling, adaptation off ---
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_random(300);
    settle();
    write_adapt(1'b1);

    // --- back-pressure: receiver holds off while last-quad words keep coming ---
    src_idle = 1'b0;
    @(posedge clk_i);
    hold_left = 80;
    @(negedge clk_i);
    for (int i = 0; i < 30; i++) begin
      send_quad(make_quad(), 1'b1);
    end
    settle();  // sender pauses until all thresholds are in

    src_idle = 1'b1;
    run_random(500);

    // --- short phases, register flipped between them, often mid-block ---
    for (int p = 0; p < 4; p++) begin
      settle();
      write_adapt(p[0]);
      run_random(120);
    end
    settle();

    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/qste_pkg.sv
sv/qste_step.sv
sv/quad_step_threshold_estimator.sv
tb/tb.sv
